@@ rtl/core/nrl_pkg.sv @@
// shared types and constants of the ntp request rate limiter
`default_nettype none

package nrl_pkg;

   localparam int BUCKETS = 64;
   localparam int BKT_W   = $clog2(BUCKETS);

   localparam logic [31:0] HASH_MULT   = 32'd2654435761;
   localparam logic [7:0]  MIN_LEN     = 8'd48;
   localparam logic [15:0] CNT_MAX     = 16'hFFFF;
   localparam logic [31:0] SEC_NONE    = 32'hFFFF_FFFF;
   localparam logic [31:0] REFID_PPS   = 32'h5050_5300;
   localparam logic [31:0] REFID_RATE  = 32'h5241_5445;

   localparam logic [2:0]  MODE_RESERVED = 3'd0;
   localparam logic [2:0]  MODE_CLIENT   = 3'd3;
   localparam logic [2:0]  MODE_SERVER   = 3'd4;
   localparam logic [2:0]  VER_MIN       = 3'd3;
   localparam logic [2:0]  VER_MAX       = 3'd4;
   localparam logic [1:0]  LI_NONE       = 2'd0;
   localparam logic [1:0]  LI_ALARM      = 2'd3;
   localparam logic [4:0]  STRATUM_LOCKED = 5'd1;
   localparam logic [4:0]  STRATUM_UNSYNC = 5'd16;

   localparam logic [1:0]  CSR_CLIENT_LIMIT = 2'd0;
   localparam logic [1:0]  CSR_GLOBAL_LIMIT = 2'd1;
   localparam logic [1:0]  CSR_WARM_GATE    = 2'd2;

   typedef enum logic [2:0] {
      ACT_SHORT  = 3'd0,
      ACT_MODE   = 3'd1,
      ACT_REPLY  = 3'd2,
      ACT_KOD    = 3'd3,
      ACT_COLD   = 3'd4,
      ACT_COMMIT = 3'd5
   } action_type;

   typedef struct packed {
      logic        op;
      logic [31:0] client_ip;
      logic [31:0] current_sec;
      logic [7:0]  request_len;
      logic [7:0]  first_byte;
      logic        clock_locked;
   } req_type;

   typedef struct packed {
      action_type  action;
      logic [7:0]  reply_byte0;
      logic [4:0]  stratum;
      logic [31:0] ref_id;
      logic        zero_root;
      logic [5:0]  bucket;
   } rsp_type;

   typedef struct packed {
      logic [31:0] second;
      logic [15:0] count;
   } entry_type;

   typedef struct packed {
      logic      counted;
      logic      commit;
      entry_type entry;
      entry_type window;
   } upd_type;

   typedef struct packed {
      logic [15:0] client_limit;
      logic [15:0] global_limit;
      logic        warm_gate;
   } cfg_type;

endpackage

`default_nettype wire

@@ rtl/core/nrl_bucket_store.sv @@
// per-bucket second and count memory with valid bits and write-to-read bypass
`default_nettype none

module nrl_bucket_store
   import nrl_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             rd_en,
   input  wire logic [BKT_W-1:0] rd_addr,
   input  wire logic             wr_en,
   input  wire logic [BKT_W-1:0] wr_addr,
   input  wire entry_type        wr_data,
   output      entry_type        rd_entry
);

   entry_type          mem_ff [BUCKETS];
   logic [BUCKETS-1:0] valid_ff;
   logic [BUCKETS-1:0] valid_in;
   entry_type          rd_data_ff;
   logic               rd_valid_ff;
   logic               byp_ff;
   entry_type          byp_data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // read returns the old word; a same-cycle write is caught by the bypass
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff  <= mem_ff[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
         byp_ff      <= wr_en && (wr_addr == rd_addr);
         byp_data_ff <= wr_data;
      end
   end

   always_comb begin
      if (byp_ff) begin
         rd_entry = byp_data_ff;
      end else if (rd_valid_ff) begin
         rd_entry = rd_data_ff;
      end else begin
         rd_entry = '{second: SEC_NONE, count: 16'd0};
      end
   end

   a_bypass: assert property (@(posedge clock) disable iff (reset)
      rd_en && wr_en && (rd_addr == wr_addr) |=> rd_entry == $past(wr_data))
      else $error("bypass lost a same-cycle write");

   a_valid_set: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> valid_ff[$past(wr_addr)])
      else $error("written entry not marked valid");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> valid_ff == '0)
      else $error("valid bits not cleared by reset");

endmodule

`default_nettype wire

@@ rtl/core/nrl_decide.sv @@
// screening, count update and reply header selection for one item
`default_nettype none

module nrl_decide
   import nrl_pkg::*;
(
   input  wire req_type          item,
   input  wire logic [BKT_W-1:0] bucket,
   input  wire entry_type        entry,
   input  wire entry_type        window,
   input  wire logic             warm,
   input  wire cfg_type          cfg,
   output      rsp_type          rsp,
   output      upd_type          upd
);

   logic [2:0]  mode;
   logic [2:0]  ver;
   logic [15:0] bcnt;
   logic [15:0] wcnt;
   logic        over;
   logic        locked;

   always_comb begin
      mode   = item.first_byte[2:0];
      ver    = item.first_byte[5:3];
      locked = item.clock_locked;
      if (ver < VER_MIN) begin
         ver = VER_MIN;
      end else if (ver > VER_MAX) begin
         ver = VER_MAX;
      end

      // a new second restarts the count, counts saturate
      bcnt = (entry.second == item.current_sec) ? entry.count : 16'd0;
      if (bcnt != CNT_MAX) begin
         bcnt = bcnt + 16'd1;
      end
      wcnt = (window.second == item.current_sec) ? window.count : 16'd0;
      if (wcnt != CNT_MAX) begin
         wcnt = wcnt + 16'd1;
      end
      over = (bcnt > cfg.client_limit) || (wcnt > cfg.global_limit);

      upd.counted = 1'b0;
      upd.commit  = 1'b0;
      upd.entry   = '{second: item.current_sec, count: bcnt};
      upd.window  = '{second: item.current_sec, count: wcnt};

      rsp = '{action: ACT_SHORT, reply_byte0: 8'd0, stratum: 5'd0, ref_id: 32'd0,
              zero_root: 1'b0, bucket: 6'd0};

      if (item.op) begin
         upd.commit = 1'b1;
         rsp.action = ACT_COMMIT;
         rsp.bucket = bucket;
      end else if (item.request_len < MIN_LEN) begin
         rsp.action = ACT_SHORT;
      end else if ((mode != MODE_CLIENT) && (mode != MODE_RESERVED)) begin
         rsp.action = ACT_MODE;
      end else begin
         upd.counted = 1'b1;
         rsp.bucket  = bucket;
         if (over && cfg.warm_gate && !warm) begin
            rsp.action = ACT_COLD;
         end else if (over) begin
            rsp.action      = ACT_KOD;
            rsp.reply_byte0 = {LI_ALARM, ver, MODE_SERVER};
            rsp.ref_id      = REFID_RATE;
            rsp.zero_root   = 1'b1;
         end else begin
            rsp.action      = ACT_REPLY;
            rsp.reply_byte0 = {(locked ? LI_NONE : LI_ALARM), ver, MODE_SERVER};
            rsp.stratum     = locked ? STRATUM_LOCKED : STRATUM_UNSYNC;
            rsp.ref_id      = locked ? REFID_PPS : 32'd0;
         end
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/ntp_request_rate_limiter.sv @@
// ntp request rate limiter: input stage, hashed bucket read, decision and result register
// throughput: one item per cycle unless rsp_tready stalls; a bucket is read as the item
// enters the decision stage and written as it leaves, with a bypass for back-to-back hits
// reset: synchronous; clears pipeline valids, bucket valid bits, warm bits, the global
// window and restores the configuration defaults; no clearing pass is needed
`default_nettype none

module ntp_request_rate_limiter
   import nrl_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [87:0] req_tdata,  // client_ip, current_sec, request_len, first_byte,
                                        // clock_locked
   input  wire logic        req_tuser,  // op
   // result channel
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [55:0] rsp_tdata,  // reply_byte0, stratum, ref_id, zero_root, bucket
   output      logic [2:0]  rsp_tuser,  // action
   // configuration
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_addr,
   input  wire logic [15:0] csr_wdata
);

   cfg_type            cfg_ff, cfg_in;
   logic               a_v_ff, a_v_in;
   req_type            a_item_ff;
   logic               b_v_ff, b_v_in;
   req_type            b_item_ff;
   logic [BKT_W-1:0]   b_bucket_ff;
   logic               rsp_v_ff, rsp_v_in;
   rsp_type            rsp_data_ff;
   logic [BUCKETS-1:0] warm_ff, warm_in;
   entry_type          win_ff, win_in;

   logic               rsp_load, b_move, b_free, a_move, a_free, req_acc;
   logic [31:0]        hash_prod;
   logic [BKT_W-1:0]   a_bucket;
   logic               wr_en;
   entry_type          rd_entry;
   rsp_type            dec_rsp;
   upd_type            dec_upd;
   req_type            req_item;

   assign rsp_load = !rsp_v_ff || rsp_tready;
   assign b_move   = b_v_ff && rsp_load;
   assign b_free   = !b_v_ff || rsp_load;
   assign a_move   = a_v_ff && b_free;
   assign a_free   = !a_v_ff || b_free;
   assign req_acc  = req_tvalid && a_free;

   assign req_tready = a_free;
   assign req_item   = '{op: req_tuser, client_ip: req_tdata[31:0],
                         current_sec: req_tdata[63:32], request_len: req_tdata[71:64],
                         first_byte: req_tdata[79:72], clock_locked: req_tdata[80]};

   // knuth multiplicative hash, bucket from the top bits
   assign hash_prod = a_item_ff.client_ip * HASH_MULT;
   assign a_bucket  = hash_prod[31 -: BKT_W];

   assign wr_en = b_move && dec_upd.counted;

   nrl_bucket_store u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (a_move),
      .rd_addr  (a_bucket),
      .wr_en    (wr_en),
      .wr_addr  (b_bucket_ff),
      .wr_data  (dec_upd.entry),
      .rd_entry (rd_entry)
   );

   nrl_decide u_decide (
      .item   (b_item_ff),
      .bucket (b_bucket_ff),
      .entry  (rd_entry),
      .window (win_ff),
      .warm   (warm_ff[b_bucket_ff]),
      .cfg    (cfg_ff),
      .rsp    (dec_rsp),
      .upd    (dec_upd)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_CLIENT_LIMIT: cfg_in.client_limit = csr_wdata;
            CSR_GLOBAL_LIMIT: cfg_in.global_limit = csr_wdata;
            CSR_WARM_GATE:    cfg_in.warm_gate    = csr_wdata[0];
            default:          cfg_in = cfg_ff;
         endcase
      end

      a_v_in = req_acc ? 1'b1 : (a_move ? 1'b0 : a_v_ff);
      b_v_in = a_move ? 1'b1 : (b_move ? 1'b0 : b_v_ff);
      rsp_v_in = b_move ? 1'b1 : (rsp_tready ? 1'b0 : rsp_v_ff);

      warm_in = warm_ff;
      if (b_move && dec_upd.commit) begin
         warm_in[b_bucket_ff] = 1'b1;
      end
      win_in = wr_en ? dec_upd.window : win_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff   <= '{client_limit: 16'd20, global_limit: 16'd200, warm_gate: 1'b1};
         a_v_ff   <= 1'b0;
         b_v_ff   <= 1'b0;
         rsp_v_ff <= 1'b0;
         warm_ff  <= '0;
         win_ff   <= '{second: 32'd0, count: 16'd0};
      end else begin
         cfg_ff   <= cfg_in;
         a_v_ff   <= a_v_in;
         b_v_ff   <= b_v_in;
         rsp_v_ff <= rsp_v_in;
         warm_ff  <= warm_in;
         win_ff   <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         a_item_ff <= req_item;
      end
      if (a_move) begin
         b_item_ff   <= a_item_ff;
         b_bucket_ff <= a_bucket;
      end
      if (b_move) begin
         rsp_data_ff <= dec_rsp;
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tuser  = rsp_data_ff.action;
   assign rsp_tdata  = {4'd0, rsp_data_ff.bucket, rsp_data_ff.zero_root,
                        rsp_data_ff.ref_id, rsp_data_ff.stratum, rsp_data_ff.reply_byte0};

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      b_v_ff && !rsp_load |=> b_v_ff && $stable(b_item_ff) && $stable(b_bucket_ff))
      else $error("decision stage lost an item under stall");

   a_commit_warm: assert property (@(posedge clock) disable iff (reset)
      b_move && b_item_ff.op |=> warm_ff[$past(b_bucket_ff)])
      else $error("commit did not warm its bucket");

   a_window_count: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> win_ff.count != 16'd0)
      else $error("counted request left the window count at zero");

endmodule

`default_nettype wire
